/* src/mean_squared_error_loss_core_assert.svh */
// Assertion macros for the MSE loss core.
// Included by files that check internal invariants; relies on clk and rst_n in scope.
`ifndef MEAN_SQUARED_ERROR_LOSS_CORE_ASSERT_SVH
`define MEAN_SQUARED_ERROR_LOSS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define MSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define MSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSE_ASSERT(lbl, prop, msg)
`define MSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/msel_pkg.sv */
// Shared types and constants for the MSE loss core.
// No dependencies; imported by every module of the core.
package msel_pkg;

    localparam int ACC_W       = 40;  // row and batch accumulators
    localparam int CNT_W       = 9;   // configuration registers and counters
    localparam int LOSS_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS   = ACC_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BATCH_ROWS = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] data;
    } q_push_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic [ACC_W-1:0]  head;
    } q_stat_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [ACC_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_ROW   = 3'b010,
        B_BATCH = 3'b100
    } back_state_t;

endpackage

/* src/msel_front.sv */
// Front end: takes prediction/target pairs, squares the difference and sums rows.
// Pushes each closed row sum into the queue. Depends on msel_pkg.
module msel_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    prediction,
    input  logic signed [SAMPLE_WIDTH-1:0]    target,
    input  logic [msel_pkg::CNT_W-1:0]        len,
    input  msel_pkg::q_stat_t                 q_stat,
    output msel_pkg::q_push_t                 q_push
);
    import msel_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_WIDTH + 2;

    logic                     accept;
    logic signed [SAMPLE_WIDTH:0] diff;
    logic [SAMPLE_WIDTH:0]    mag;
    logic                     close;
    logic [CNT_W:0]           col_inc;
    logic [QCNT_W-1:0]        free;
    logic [1:0]               pending;
    logic [ACC_W-1:0]         row_total;

    logic [CNT_W-1:0]         col_reg, col_next;
    logic                     va_reg, ca_reg;
    logic [SAMPLE_WIDTH:0]    mag_a_reg;
    logic                     vb_reg, cb_reg;
    logic [SQ_W-1:0]          sq_b_reg;
    logic [ACC_W-1:0]         row_sum_reg, row_sum_next;

    // Stall when the queue could not take every row close already in flight.
    assign free     = QCNT_W'(QUEUE_DEPTH) - q_stat.count;
    assign pending  = {1'b0, va_reg & ca_reg} + {1'b0, vb_reg & cb_reg};
    assign in_ready = free > QCNT_W'(pending);
    assign accept   = in_valid & in_ready;

    assign diff    = $signed({prediction[SAMPLE_WIDTH-1], prediction})
                   - $signed({target[SAMPLE_WIDTH-1], target});
    assign mag     = diff[SAMPLE_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign close   = col_inc >= {1'b0, len};

    always_comb
    begin
        col_next = col_reg;
        if (accept)
        begin
            col_next = close ? '0 : col_inc[CNT_W-1:0];
        end
    end

    assign row_total = row_sum_reg + ACC_W'(sq_b_reg);

    always_comb
    begin
        row_sum_next = row_sum_reg;
        if (vb_reg)
        begin
            row_sum_next = cb_reg ? '0 : row_total;
        end
    end

    assign q_push.valid = vb_reg & cb_reg;
    assign q_push.data  = row_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            va_reg      <= 1'b0;
            ca_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            cb_reg      <= 1'b0;
            row_sum_reg <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            va_reg      <= accept;
            ca_reg      <= accept & close;
            vb_reg      <= va_reg;
            cb_reg      <= ca_reg;
            row_sum_reg <= row_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag;
        sq_b_reg  <= SQ_W'(mag_a_reg) * SQ_W'(mag_a_reg);
    end

endmodule

/* src/msel_queue.sv */
// Short queue of closed row sums between front and back ends.
// Register-based ring buffer; depends on msel_pkg.
module msel_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  msel_pkg::q_push_t q_push,
    input  logic              pop,
    output msel_pkg::q_stat_t q_stat
);
    import msel_pkg::*;

    logic [ACC_W-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({q_push.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign q_stat.count = count_reg;
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push.valid)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            mem_reg[wr_ptr_reg] <= q_push.data;
        end
    end

endmodule

/* src/msel_div.sv */
// Restoring divider, one quotient bit per cycle, shared by row and batch means.
// 40-bit dividend by 9-bit nonzero divisor; depends on msel_pkg.
module msel_div (
    input  logic               clk,
    input  logic               rst_n,
    input  msel_pkg::div_req_t div_req,
    output msel_pkg::div_rsp_t div_rsp
);
    import msel_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [ACC_W-1:0]     dvd_reg;
    logic [CNT_W-1:0]     dsr_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, dvd_reg[ACC_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    assign div_rsp.busy     = busy_reg;
    assign div_rsp.quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (div_req.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shift quotient bits into the dividend register as its top bits leave.
    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            dvd_reg <= div_req.dividend;
            dsr_reg <= div_req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ACC_W-2:0], ge};
            rem_reg <= ge ? CNT_W'(trial - {1'b0, dsr_reg}) : trial[CNT_W-1:0];
        end
    end

endmodule

/* src/msel_back.sv */
// Back end: turns queued row sums into row means, sums them per batch and
// emits the batch mean through an output register. Depends on msel_pkg and msel_div.
module msel_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [msel_pkg::CNT_W-1:0] len,
    input  logic [msel_pkg::CNT_W-1:0] rows,
    input  msel_pkg::q_stat_t          q_stat,
    output logic                       pop,
    output msel_pkg::div_req_t         div_req,
    input  msel_pkg::div_rsp_t         div_rsp,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [msel_pkg::LOSS_W-1:0] loss
);
    import msel_pkg::*;

    back_state_t      state_reg, state_next;
    logic [ACC_W-1:0] batch_sum_reg, batch_sum_next;
    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [LOSS_W-1:0] loss_reg, loss_next;
    logic [ACC_W-1:0] batch_total;
    logic [CNT_W:0]   row_inc;
    logic             out_free;
    logic             load;

    assign batch_total = batch_sum_reg + div_rsp.quotient;
    assign row_inc     = {1'b0, row_cnt_reg} + 1'b1;
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        batch_sum_next   = batch_sum_reg;
        row_cnt_next     = row_cnt_reg;
        pop              = 1'b0;
        load             = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = q_stat.head;
        div_req.divisor  = len;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop           = 1'b1;
                    div_req.start = 1'b1;
                    state_next    = B_ROW;
                end
            end
            B_ROW:
            begin
                if (!div_rsp.busy)
                begin
                    if (row_inc >= {1'b0, rows})
                    begin
                        // Close the batch: divide the total by the row count.
                        div_req.start    = 1'b1;
                        div_req.dividend = batch_total;
                        div_req.divisor  = rows;
                        batch_sum_next   = '0;
                        row_cnt_next     = '0;
                        state_next       = B_BATCH;
                    end
                    else
                    begin
                        batch_sum_next = batch_total;
                        row_cnt_next   = row_inc[CNT_W-1:0];
                        state_next     = B_IDLE;
                    end
                end
            end
            B_BATCH:
            begin
                if (!div_rsp.busy && out_free)
                begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        loss_next      = loss_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            loss_next      = div_rsp.quotient[LOSS_W-1:0];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign loss      = loss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            batch_sum_reg <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            batch_sum_reg <= batch_sum_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        loss_reg <= loss_next;
    end

endmodule

/* src/mean_squared_error_loss_core.sv */
// Streaming mean-squared-error loss. Each input transfer carries one signed Q8.8
// prediction/target pair; the squared differences are summed per row of
// row_length items, each row sum is divided by row_length, the row means are
// summed over batch_rows rows, and the batch mean goes out as one unsigned
// Q16.16 loss transfer. The front end takes one pair per cycle while the row queue
// has room for every row sum in flight. Every row close costs one pass of the shared
// bit-serial divider in the back end plus control states, and every batch close a
// second pass; a 4-entry queue of row sums lets the front run on while earlier rows
// are divided, so the front stalls only when the queue cannot take the row sums in
// flight, and the divider then paces the rows. A loss leaves through the output
// register once the batch division of the row that closes its batch is done.
// Configuration registers reset to 1; 0 acts as 1 and values above the maximum
// saturate. Depends on msel_pkg, msel_front, msel_queue, msel_div, msel_back.
module mean_squared_error_loss_core #(
    parameter int MAX_ROW_LEN  = 256,
    parameter int MAX_ROWS     = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // prediction [SAMPLE_WIDTH-1:0], target [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH], zero pad
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // loss [31:0]
    output logic [msel_pkg::LOSS_W-1:0]             m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    cfg_we,
    input  logic [msel_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [msel_pkg::CNT_W-1:0]              cfg_wdata
);
    import msel_pkg::*;

    logic [CNT_W-1:0] row_length_reg, batch_rows_reg;
    logic [CNT_W-1:0] len, rows;
    q_stat_t          q_stat;
    q_push_t          q_push;
    logic             q_pop;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= CNT_W'(1);
            batch_rows_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ROW_LENGTH: row_length_reg <= cfg_wdata;
                REG_BATCH_ROWS: batch_rows_reg <= cfg_wdata;
                default:        row_length_reg <= row_length_reg;
            endcase
        end
    end

    // Zero acts as one; saturate at the configured maximum.
    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len = CNT_W'(1);
        end
        else if (32'(row_length_reg) > MAX_ROW_LEN)
        begin
            len = CNT_W'(MAX_ROW_LEN);
        end
        else
        begin
            len = row_length_reg;
        end

        if (batch_rows_reg == '0)
        begin
            rows = CNT_W'(1);
        end
        else if (32'(batch_rows_reg) > MAX_ROWS)
        begin
            rows = CNT_W'(MAX_ROWS);
        end
        else
        begin
            rows = batch_rows_reg;
        end
    end

    msel_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .prediction (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .target     (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .len        (len),
        .q_stat     (q_stat),
        .q_push     (q_push)
    );

    msel_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .q_stat (q_stat)
    );

    msel_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    msel_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .len       (len),
        .rows      (rows),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .loss      (m_axis_tdata)
    );

`include "mean_squared_error_loss_core_assert.svh"

    `MSE_ASSERT(a_queue_room, q_push.valid |-> q_stat.count < QCNT_W'(QUEUE_DEPTH), "queue overflow")
    `MSE_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "pop from empty row queue")
    `MSE_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")

endmodule

/* dv/msel_loss_checker.sv */
// Loss checker for the MSE loss core: watches the register port and both streams,
// predicts each loss transfer from the accepted pairs and compares it.
// Depends on msel_pkg for widths and register indexes.
`timescale 1ns / 1ps

module msel_loss_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [31:0]                       s_axis_tdata,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [msel_pkg::LOSS_W-1:0]       m_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [msel_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [msel_pkg::CNT_W-1:0]        cfg_wdata,
    output int                                fail_count,
    output int                                losses_pending,
    output int                                losses_seen
);
    import msel_pkg::*;

    localparam int unsigned ROW_LEN_LIMIT = 256;
    localparam int unsigned ROWS_LIMIT    = 256;

    logic [CNT_W-1:0]  row_length_reg;
    logic [CNT_W-1:0]  batch_rows_reg;
    int unsigned       cols_done;
    int unsigned       rows_done;
    logic [ACC_W-1:0]  row_acc;
    logic [ACC_W-1:0]  batch_acc;
    logic [LOSS_W-1:0] expected_losses [$];
    logic [LOSS_W-1:0] expected_loss;
    int                errors;
    int                seen;

    // Zero counts as one; anything above the limit saturates.
    function automatic int unsigned effective_count(input logic [CNT_W-1:0] v,
                                                    input int unsigned limit);
        if (v == '0)
            return 1;
        if (32'(v) > limit)
            return limit;
        return 32'(v);
    endfunction

    task automatic accumulate_pair(input logic signed [15:0] prediction,
                                   input logic signed [15:0] target);
        int unsigned        len;
        int unsigned        rows;
        logic signed [16:0] diff;
        logic [16:0]        mag;
        logic [33:0]        sq;
        len  = effective_count(row_length_reg, ROW_LEN_LIMIT);
        rows = effective_count(batch_rows_reg, ROWS_LIMIT);
        diff = 17'(prediction) - 17'(target);
        mag  = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);
        sq   = 34'(mag) * 34'(mag);
        row_acc = row_acc + ACC_W'(sq);
        cols_done++;
        // A count already past a lowered setting closes on the next pair.
        if (cols_done >= len)
        begin
            batch_acc = batch_acc + row_acc / ACC_W'(len);
            row_acc   = '0;
            cols_done = 0;
            rows_done++;
            if (rows_done >= rows)
            begin
                expected_losses = {expected_losses, LOSS_W'(batch_acc / ACC_W'(rows))};
                batch_acc = '0;
                rows_done = 0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            row_length_reg = CNT_W'(1);
            batch_rows_reg = CNT_W'(1);
            cols_done      = 0;
            rows_done      = 0;
            row_acc        = '0;
            batch_acc      = '0;
            errors         = 0;
            seen           = 0;
            expected_losses.delete();
        end
        else
        begin
            // Compare before adding new pairs: a loss never leaves in its own cycle.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen++;
                if (expected_losses.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected loss transfer, expected none, got 0x%08h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    expected_loss = expected_losses.pop_front();
                    if (m_axis_tdata !== expected_loss)
                    begin
                        errors++;
                        $display("%0t: loss mismatch, expected 0x%08h, got 0x%08h",
                                 $time, expected_loss, m_axis_tdata);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ROW_LENGTH: row_length_reg = cfg_wdata;
                    REG_BATCH_ROWS: batch_rows_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                accumulate_pair(s_axis_tdata[15:0], s_axis_tdata[31:16]);
        end
        fail_count     <= errors;
        losses_pending <= expected_losses.size();
        losses_seen    <= seen;
    end

endmodule

/* dv/tb_mean_squared_error_loss_core.sv */
// Top of the MSE loss core testbench: clock, reset, pair stimulus, register
// writes and output back-pressure; checking lives in msel_loss_checker.
// Depends on msel_pkg, mean_squared_error_loss_core and msel_loss_checker.
`timescale 1ns / 1ps

module tb_mean_squared_error_loss_core;
    import msel_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_PAIRS  = 360;

    logic                  clk;
    logic                  rst_n;
    logic [31:0]           s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [LOSS_W-1:0]     m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CNT_W-1:0]      cfg_wdata;

    int                    fail_count;
    int                    losses_pending;
    int                    losses_seen;
    int                    burst_left;
    int                    pairs_sent;
    int                    settings_used;
    logic [9:0]            stall_phase = '0;

    mean_squared_error_loss_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    msel_loss_checker loss_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .losses_pending (losses_pending),
        .losses_seen    (losses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("mean_squared_error_loss_core test failed");
        $finish;
    end

    // Receiver: always ready, coin-flip, sparse, then a fixed stall pattern.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_phase[3:0] >= 4'd11);
        endcase
    end

    task automatic push_pair(input logic [15:0] prediction, input logic [15:0] target);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 :
                  ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target, prediction};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pairs_sent++;
    endtask

    // Hold the sender until every predicted loss has been taken.
    task automatic wait_for_losses();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (losses_pending != 0)
            @(posedge clk);
    endtask

    // Give the back end time to finish row divisions that produce no transfer.
    task automatic settle();
        wait_for_losses();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int unsigned row_length,
                             input int unsigned batch_rows);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ROW_LENGTH;
        cfg_wdata <= CNT_W'(row_length);
        @(posedge clk);
        cfg_addr  <= REG_BATCH_ROWS;
        cfg_wdata <= CNT_W'(batch_rows);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic pick_pair(output logic [15:0] prediction, output logic [15:0] target);
        logic [15:0] corners [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 55)
        begin
            prediction = 16'($urandom);
            target     = 16'($urandom);
        end
        else if (mode < 70)
        begin
            prediction = 16'(int'($urandom_range(0, 1023)) - 512);
            target     = 16'(int'($urandom_range(0, 1023)) - 512);
        end
        else if (mode < 85)
        begin
            prediction = corners[$urandom_range(0, 4)];
            target     = corners[$urandom_range(0, 4)];
        end
        else
        begin
            // equal or nearly equal: zero or tiny error
            prediction = 16'($urandom);
            target     = prediction ^ 16'($urandom_range(0, 3));
        end
    endtask

    // Mostly full-scale error of either sign, to drive the sums to their top.
    task automatic pick_wide_pair(output logic [15:0] prediction, output logic [15:0] target);
        if ($urandom_range(0, 3) == 0)
            pick_pair(prediction, target);
        else if ($urandom_range(0, 1) == 0)
        begin
            prediction = 16'h7FFF;
            target     = 16'h8000;
        end
        else
        begin
            prediction = 16'h8000;
            target     = 16'h7FFF;
        end
    endtask

    initial
    begin
        logic [15:0] dir_pred [10] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF,
                                       16'h0001, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
        logic [15:0] dir_targ [10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF,
                                       16'h0000, 16'h0000, 16'h0001, 16'hAAAA, 16'h5555};
        int unsigned ext_len  [2] = '{511, 1};
        int unsigned ext_rows [2] = '{1, 511};
        logic [15:0] p;
        logic [15:0] t;
        int          random_pairs;
        int unsigned len;
        int unsigned rows;
        int unsigned span;
        int unsigned count;

        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_ROW_LENGTH;
        cfg_wdata     = '0;
        burst_left    = 0;
        pairs_sent    = 0;
        settings_used = 0;
        random_pairs  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every pair is its own batch.
        for (int i = 0; i < 10; i++)
            push_pair(dir_pred[i], dir_targ[i]);

        // Zero in both registers acts as one.
        configure(0, 0);
        for (int i = 0; i < 2; i++)
        begin
            pick_pair(p, t);
            push_pair(p, t);
        end

        // Shrink the row length under a partial row, then the batch under a partial batch.
        configure(4, 2);
        for (int i = 0; i < 3; i++)
        begin
            pick_pair(p, t);
            push_pair(p, t);
        end
        configure(2, 2);
        for (int i = 0; i < 3; i++)
        begin
            pick_pair(p, t);
            push_pair(p, t);
        end
        configure(1, 3);
        for (int i = 0; i < 2; i++)
        begin
            pick_pair(p, t);
            push_pair(p, t);
        end
        configure(1, 1);
        pick_pair(p, t);
        push_pair(p, t);

        // Largest and saturating settings, one batch each.
        for (int k = 0; k < 2; k++)
        begin
            configure(ext_len[k], ext_rows[k]);
            for (int i = 0; i < 256; i++)
            begin
                pick_wide_pair(p, t);
                push_pair(p, t);
            end
        end

        wait_for_losses();
        while (random_pairs < RANDOM_PAIRS)
        begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 64);
            rows = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
            configure(len, rows);
            span  = (len == 0 ? 1 : len) * (rows == 0 ? 1 : rows);
            count = span * ((span > 200) ? 1 : $urandom_range(1, 3));
            // leave a partial row or batch behind for the next setting now and then
            if (span > 1 && $urandom_range(0, 2) == 0)
                count += $urandom_range(1, span - 1);
            for (int unsigned i = 0; i < count && random_pairs < RANDOM_PAIRS; i++)
            begin
                if ($urandom_range(0, 79) == 0)
                    wait_for_losses();
                pick_pair(p, t);
                push_pair(p, t);
                random_pairs++;
            end
        end

        settle();
        $display("Sent %0d pairs (%0d in the random part) under %0d register settings.",
                 pairs_sent, random_pairs, settings_used);
        $display("Checked %0d loss transfers, including full-scale and saturated settings.",
                 losses_seen);
        if (fail_count == 0 && losses_pending == 0)
            $display("mean_squared_error_loss_core test passed");
        else
            $display("mean_squared_error_loss_core test failed");
        $finish;
    end

endmodule
